// ----- hw/rtl/pam_pkg.sv -----
// shared types and constants for the missing-event probability block
`default_nettype none
package pam_pkg;
  localparam int MAX_EVENTS = 8;
  localparam int EV_IDX_W   = 3;
  localparam int CNT_W      = 4;
  localparam int MAX_TRIALS = 64;
  localparam int T_W        = 7;
  localparam int TIDX_W     = 6;
  localparam int FRAC_BITS  = 31;
  localparam int PROB_W     = 32;
  localparam int SUM_W      = 35;
  localparam int ACC_W      = 48;
  localparam int PROD_W     = 64;
  localparam int MASK_W     = 8;

  localparam logic [PROB_W-1:0] ONE_Q = PROB_W'(64'd1 << FRAC_BITS);
  localparam logic [PROD_W-1:0] HALF_Q = PROD_W'(64'd1 << (FRAC_BITS - 1));

  typedef struct packed {
    logic [MAX_EVENTS-1:0][PROB_W-1:0] probs;
    logic [CNT_W-1:0]                  n;
    logic [T_W-1:0]                    t_max;
    logic                              series;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MAG,
    ST_MUL,
    ST_ACC,
    ST_ORD,
    ST_OWAIT,
    ST_OHOLD
  } back_state_e;
endpackage
`default_nettype wire

// ----- hw/rtl/prob_any_event_missing.sv -----
// top level: probability that at least one event never occurs in t trials
// input channel (in_valid_i/in_ready_o) takes one probability request per
// cycle into a load store while the queue has room; the request with
// last_event_i closes the set, carries the trial count and becomes a job
// in a two-entry queue. the back end walks every nonempty subset of the set:
// it forms the subset sum over every load slot, then the base, then for
// each trial count one multiply and one accumulate into a 64-entry
// accumulator memory. the subset and power loop sets the rate; each emitted
// result also passes through the ORD, OWAIT and OHOLD states.
// results leave on out_valid_o/out_ready_i from an output register: one in
// single mode, T in series mode (cfg_we_i/cfg_wdata_i set series mode).
// a stalled receiver holds the back end; the front keeps loading the next
// set until the queue is full.
// reset clears the load count, queue, engine state and series mode.
`default_nettype none
module prob_any_event_missing (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire                        cfg_wdata_i,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire [pam_pkg::PROB_W-1:0]  event_prob_i,
  input  wire [pam_pkg::T_W-1:0]     trial_count_i,
  input  wire                        last_event_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [pam_pkg::PROB_W-1:0] missing_prob_o,
  output logic [pam_pkg::T_W-1:0]    trials_used_o,
  output logic                       last_result_o
);
  logic          series_q;
  logic          push, push_ready, job_valid, pop;
  pam_pkg::job_t push_job, head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) series_q <= 1'b0;
    else if (cfg_we_i) series_q <= cfg_wdata_i;
  end

  pam_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .event_prob_i, .trial_count_i,
    .last_event_i, .series_i(series_q), .push_o(push), .push_ready_i(push_ready),
    .job_o(push_job)
  );

  pam_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_ready_o(push_ready), .push_job_i(push_job),
    .pop_valid_o(job_valid), .pop_i(pop), .pop_job_o(head_job)
  );

  pam_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(head_job), .pop_o(pop),
    .out_valid_o, .out_ready_i, .missing_prob_o, .trials_used_o, .last_result_o
  );
endmodule
`default_nettype wire

// ----- hw/rtl/pam_front.sv -----
// front end: loads probabilities and builds one job per set
`default_nettype none
module pam_front (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire [pam_pkg::PROB_W-1:0]   event_prob_i,
  input  wire [pam_pkg::T_W-1:0]      trial_count_i,
  input  wire                         last_event_i,
  input  wire                         series_i,
  output logic                        push_o,
  input  wire                         push_ready_i,
  output pam_pkg::job_t               job_o
);
  logic [pam_pkg::CNT_W-1:0] count_q, count_d;
  logic [pam_pkg::MAX_EVENTS-1:0][pam_pkg::PROB_W-1:0] store_q, store_d;
  logic accept;
  logic room;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign room       = (count_q < pam_pkg::CNT_W'(pam_pkg::MAX_EVENTS));

  always_comb begin
    store_d = store_q;
    if (room) begin
      store_d[count_q[pam_pkg::EV_IDX_W-1:0]] = event_prob_i;
    end
    count_d = room ? count_q + pam_pkg::CNT_W'(1) : count_q;
  end

  always_comb begin
    job_o.probs  = store_d;
    job_o.n      = count_d;
    job_o.series = series_i;
    if (trial_count_i == '0) begin
      job_o.t_max = pam_pkg::T_W'(1);
    end else if (trial_count_i > pam_pkg::T_W'(pam_pkg::MAX_TRIALS)) begin
      job_o.t_max = pam_pkg::T_W'(pam_pkg::MAX_TRIALS);
    end else begin
      job_o.t_max = trial_count_i;
    end
    push_o = accept & last_event_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= last_event_i ? '0 : count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q <= store_d;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/pam_queue.sv -----
// two-entry job queue between front and back
`default_nettype none
module pam_queue (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_i,
  output logic          push_ready_o,
  input  pam_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  wire           pop_i,
  output pam_pkg::job_t pop_job_o
);
  pam_pkg::job_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_job_o    = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_job_i;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/pam_back.sv -----
// back end: subset walk, power chain, per-trial accumulators and result output
`default_nettype none
module pam_back (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         job_valid_i,
  input  pam_pkg::job_t               job_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [pam_pkg::PROB_W-1:0]  missing_prob_o,
  output logic [pam_pkg::T_W-1:0]     trials_used_o,
  output logic                        last_result_o
);
  pam_pkg::back_state_e state_q, state_d;

  logic [pam_pkg::MASK_W-1:0]   mask_q;
  logic [pam_pkg::EV_IDX_W-1:0] i_q;
  logic [pam_pkg::SUM_W-1:0]    sum_q;
  logic                         par_q;
  logic [pam_pkg::PROB_W-1:0]   mag_q, pw_q;
  logic                         base_neg_q;
  logic [pam_pkg::PROD_W-1:0]   prod_q;
  logic [pam_pkg::T_W-1:0]      t_q;
  logic signed [pam_pkg::ACC_W-1:0] mem_q [pam_pkg::MAX_TRIALS];
  logic signed [pam_pkg::ACC_W-1:0] rd_q;
  logic                         ovalid_q;
  logic [pam_pkg::PROB_W-1:0]   oval_q;

  logic [pam_pkg::T_W-1:0]      tm1;
  logic [pam_pkg::TIDX_W-1:0]   addr;
  logic [pam_pkg::MASK_W:0]     full_mask;
  logic                         last_mask, last_t;
  logic [pam_pkg::T_W-1:0]      first_t;
  logic [pam_pkg::PROB_W-1:0]   p_cl;
  logic [pam_pkg::SUM_W-1:0]    one_w, diff;
  logic [pam_pkg::PROD_W-1:0]   rounded;
  logic [pam_pkg::PROB_W-1:0]   pw_new;
  logic                         neg;
  logic signed [pam_pkg::ACC_W-1:0] base, term, acc_new;
  logic [pam_pkg::PROB_W-1:0]   val;

  assign tm1       = t_q - pam_pkg::T_W'(1);
  assign addr      = tm1[pam_pkg::TIDX_W-1:0];
  assign full_mask = (pam_pkg::MASK_W+1)'((10'd1 << job_i.n) - 10'd1);
  assign last_mask = ({1'b0, mask_q} == full_mask);
  assign last_t    = (t_q == job_i.t_max);
  assign first_t   = job_i.series ? pam_pkg::T_W'(1) : job_i.t_max;
  assign p_cl      = (job_i.probs[i_q] > pam_pkg::ONE_Q) ? pam_pkg::ONE_Q : job_i.probs[i_q];
  assign one_w     = pam_pkg::SUM_W'(pam_pkg::ONE_Q);
  assign diff      = sum_q - one_w;
  assign rounded   = prod_q + pam_pkg::HALF_Q;
  assign pw_new    = (t_q == pam_pkg::T_W'(1)) ? mag_q :
                     rounded[pam_pkg::FRAC_BITS+pam_pkg::PROB_W-1:pam_pkg::FRAC_BITS];
  assign neg       = (~par_q) ^ (base_neg_q & t_q[0]);
  assign base      = (mask_q == pam_pkg::MASK_W'(1)) ? '0 : rd_q;
  assign term      = neg ? -$signed({16'd0, pw_new}) : $signed({16'd0, pw_new});
  assign acc_new   = base + term;

  always_comb begin
    if (t_q < pam_pkg::T_W'(job_i.n)) begin
      val = pam_pkg::ONE_Q;
    end else if (rd_q < 0) begin
      val = '0;
    end else if (rd_q > $signed(pam_pkg::ACC_W'(pam_pkg::ONE_Q))) begin
      val = pam_pkg::ONE_Q;
    end else begin
      val = rd_q[pam_pkg::PROB_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pam_pkg::ST_IDLE:  if (job_valid_i) state_d = pam_pkg::ST_SUM;
      pam_pkg::ST_SUM:   if (i_q == '1) state_d = pam_pkg::ST_MAG;
      pam_pkg::ST_MAG:   state_d = pam_pkg::ST_MUL;
      pam_pkg::ST_MUL:   state_d = pam_pkg::ST_ACC;
      pam_pkg::ST_ACC: begin
        if (!last_t) state_d = pam_pkg::ST_MUL;
        else if (last_mask) state_d = pam_pkg::ST_ORD;
        else state_d = pam_pkg::ST_SUM;
      end
      pam_pkg::ST_ORD:   state_d = pam_pkg::ST_OWAIT;
      pam_pkg::ST_OWAIT: state_d = pam_pkg::ST_OHOLD;
      pam_pkg::ST_OHOLD: begin
        if (out_ready_i) state_d = last_t ? pam_pkg::ST_IDLE : pam_pkg::ST_ORD;
      end
      default:           state_d = pam_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o = (state_q == pam_pkg::ST_OHOLD) & out_ready_i & last_t;
  end

  assign out_valid_o    = ovalid_q;
  assign missing_prob_o = oval_q;
  assign trials_used_o  = t_q;
  assign last_result_o  = last_t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pam_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == pam_pkg::ST_OWAIT) ovalid_q <= 1'b1;
      else if (state_q == pam_pkg::ST_OHOLD && out_ready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[addr];
    if (state_q == pam_pkg::ST_ACC) mem_q[addr] <= acc_new;
    case (state_q)
      pam_pkg::ST_IDLE: begin
        mask_q <= pam_pkg::MASK_W'(1);
        i_q    <= '0;
        sum_q  <= '0;
        par_q  <= 1'b0;
      end
      pam_pkg::ST_SUM: begin
        i_q <= i_q + pam_pkg::EV_IDX_W'(1);
        if (mask_q[i_q]) begin
          sum_q <= sum_q + pam_pkg::SUM_W'(p_cl);
          par_q <= ~par_q;
        end
      end
      pam_pkg::ST_MAG: begin
        t_q <= pam_pkg::T_W'(1);
        if (sum_q <= one_w) begin
          mag_q      <= pam_pkg::PROB_W'(one_w - sum_q);
          base_neg_q <= 1'b0;
        end else begin
          mag_q      <= (diff > one_w) ? pam_pkg::ONE_Q : pam_pkg::PROB_W'(diff);
          base_neg_q <= 1'b1;
        end
      end
      pam_pkg::ST_MUL: begin
        prod_q <= pam_pkg::PROD_W'(pw_q) * pam_pkg::PROD_W'(mag_q);
      end
      pam_pkg::ST_ACC: begin
        pw_q <= pw_new;
        if (!last_t) begin
          t_q <= t_q + pam_pkg::T_W'(1);
        end else if (last_mask) begin
          t_q <= first_t;
        end else begin
          mask_q <= mask_q + pam_pkg::MASK_W'(1);
          i_q    <= '0;
          sum_q  <= '0;
          par_q  <= 1'b0;
        end
      end
      pam_pkg::ST_OWAIT: oval_q <= val;
      pam_pkg::ST_OHOLD: if (out_ready_i && !last_t) t_q <= t_q + pam_pkg::T_W'(1);
      default: ;
    endcase
  end
endmodule
`default_nettype wire
